@@ rtl/sfpr_pkg.sv @@
package sfpr_pkg;

    localparam int MAX_LEN     = 32;
    localparam int STORE_DEPTH = 32;
    localparam int LEN_CAP     = (MAX_LEN < STORE_DEPTH) ? MAX_LEN : STORE_DEPTH;
    localparam int HDR_BYTES   = 6;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;
    localparam logic [1:0] CFG_CKS_EN      = 2'd3;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_CHECKSUM = 2'd1,
        STAT_TIMEOUT  = 2'd2,
        STAT_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_LOAD,
        ST_FINAL
    } t_state;

endpackage

@@ rtl/sync_framed_packet_receiver.sv @@
// A byte or tick that ends a frame in error shows its status result in the next cycle.
// A good frame's checksum byte is followed by its parameter results, each read from the store
// (ST_READ) and then loaded into the output register (ST_LOAD), and then by the status.
// Input takes one byte or tick per cycle while receiving and the output register is free;
// it is held off during a parameter burst, since the parameter store has a single read port.
// Reset (synchronous, active low) restores register defaults and starts the sync hunt.
module sync_framed_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // param_index, param_byte, status, device_code,
                                        // param_length, unit_code, method_id
    output logic        m_axis_tuser,   // is_frame_end
    output logic        m_axis_tlast    // last
);
    import sfpr_pkg::*;

    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    logic [15:0] r_timeout;
    logic        r_cks_en;

    t_state      r_state, n_state;
    logic [6:0]  r_pos, n_pos;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_flen, n_flen;
    logic [7:0]  r_unit, n_unit;
    logic [7:0]  r_method, n_method;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_idle, n_idle;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    logic [7:0]  r_mem [STORE_DEPTH];
    logic [7:0]  r_rd_data;
    logic        c_mem_we;
    logic [IDX_W-1:0] c_mem_addr;

    logic        r_out_valid, n_out_valid;
    logic [47:0] r_out_data, n_out_data;
    logic        r_out_end, n_out_end;
    logic        r_out_last, n_out_last;

    logic        c_out_free;
    logic        c_in_acc;
    logic [6:0]  c_count;
    logic [16:0] c_idle_next;
    logic        c_good;
    logic        c_last_param;

    assign c_out_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_RUN) && c_out_free;
    assign c_in_acc     = s_axis_tvalid && s_axis_tready;
    assign c_count      = r_pos + 7'd1;
    assign c_idle_next  = {1'b0, r_idle} + 17'd1;
    assign c_good       = (s_axis_tdata == r_sum) || !r_cks_en;
    assign c_mem_addr   = IDX_W'(c_count - 7'(HDR_BYTES + 1));
    assign c_last_param = ({1'b0, r_rd_idx} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(r_flen);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_end;
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= 8'd85;
            r_sync_second <= 8'd170;
            r_timeout     <= 16'd1400;
            r_cks_en      <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                CFG_TIMEOUT:     r_timeout     <= i_cfg_data;
                CFG_CKS_EN:      r_cks_en      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_mem_we) begin
            r_mem[c_mem_addr] <= s_axis_tdata;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_pos       <= '0;
            r_dev       <= '0;
            r_flen      <= '0;
            r_unit      <= '0;
            r_method    <= '0;
            r_sum       <= '0;
            r_idle      <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_dev       <= n_dev;
            r_flen      <= n_flen;
            r_unit      <= n_unit;
            r_method    <= n_method;
            r_sum       <= n_sum;
            r_idle      <= n_idle;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_end  <= n_out_end;
        r_out_last <= n_out_last;
    end

    function automatic logic [47:0] pack_out(
        input logic [IDX_W-1:0] idx,
        input logic [7:0]       val,
        input t_status          st,
        input logic [7:0]       dev,
        input logic [7:0]       flen,
        input logic [7:0]       unit,
        input logic [7:0]       method
    );
        pack_out = {method, unit, flen, dev, st, val, 6'(idx)};
    endfunction

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_dev       = r_dev;
        n_flen      = r_flen;
        n_unit      = r_unit;
        n_method    = r_method;
        n_sum       = r_sum;
        n_idle      = r_idle;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_end   = r_out_end;
        n_out_last  = r_out_last;
        c_mem_we    = 1'b0;

        unique case (r_state)
            ST_RUN: begin
                if (c_in_acc) begin
                    if (s_axis_tuser == REQ_TICK) begin
                        if (r_pos != '0) begin
                            if (c_idle_next > {1'b0, r_timeout}) begin
                                n_out_valid = 1'b1;
                                n_out_end   = 1'b1;
                                n_out_last  = 1'b1;
                                n_out_data  = pack_out('0, 8'd0, STAT_TIMEOUT,
                                                       r_dev, r_flen, r_unit, r_method);
                                n_pos  = '0;
                                n_idle = '0;
                                n_sum  = '0;
                            end else begin
                                n_idle = c_idle_next[15:0];
                            end
                        end
                    end else begin
                        n_idle = '0;
                        if (c_count == 7'd1) begin
                            if (s_axis_tdata == r_sync_first) begin
                                n_dev    = '0;
                                n_flen   = '0;
                                n_unit   = '0;
                                n_method = '0;
                                n_sum    = s_axis_tdata;
                                n_pos    = 7'd1;
                            end
                        end else if (c_count == 7'd2) begin
                            if (s_axis_tdata == r_sync_second) begin
                                n_sum = r_sum + s_axis_tdata;
                                n_pos = 7'd2;
                            end else begin
                                n_pos = '0;
                                n_sum = '0;
                            end
                        end else if (c_count <= 7'(HDR_BYTES)) begin
                            case (c_count)
                                7'd3:    n_dev    = s_axis_tdata;
                                7'd4:    n_flen   = s_axis_tdata;
                                7'd5:    n_unit   = s_axis_tdata;
                                default: n_method = s_axis_tdata;
                            endcase
                            n_sum = r_sum + s_axis_tdata;
                            n_pos = c_count;
                        end else if ({2'b0, c_count} < 9'(HDR_BYTES + 1) + {1'b0, r_flen}) begin
                            if (c_count >= 7'(LEN_CAP + HDR_BYTES + 1)) begin
                                n_out_valid = 1'b1;
                                n_out_end   = 1'b1;
                                n_out_last  = 1'b1;
                                n_out_data  = pack_out('0, 8'd0, STAT_TOO_LONG,
                                                       r_dev, r_flen, r_unit, r_method);
                                n_pos = '0;
                                n_sum = '0;
                            end else begin
                                c_mem_we = 1'b1;
                                n_sum    = r_sum + s_axis_tdata;
                                n_pos    = c_count;
                            end
                        end else begin
                            n_pos = '0;
                            n_sum = '0;
                            if (c_good && r_flen != '0) begin
                                n_rd_idx = '0;
                                n_state  = ST_READ;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_end   = 1'b1;
                                n_out_last  = 1'b1;
                                n_out_data  = pack_out('0, 8'd0,
                                                       c_good ? STAT_OK : STAT_CHECKSUM,
                                                       r_dev, r_flen, r_unit, r_method);
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (c_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_end   = 1'b0;
                    n_out_last  = 1'b0;
                    n_out_data  = pack_out(r_rd_idx, r_rd_data, STAT_OK,
                                           r_dev, r_flen, r_unit, r_method);
                    if (c_last_param) begin
                        n_state = ST_FINAL;
                    end else begin
                        n_rd_idx = r_rd_idx + IDX_W'(1);
                        n_state  = ST_READ;
                    end
                end
            end
            ST_FINAL: begin
                if (c_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_end   = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_data  = pack_out('0, 8'd0, STAT_OK,
                                           r_dev, r_flen, r_unit, r_method);
                    n_state     = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 7'(LEN_CAP + HDR_BYTES))
        else $error("byte position past parameter capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> (r_pos == '0 && r_idle == '0))
        else $error("hunt not restarted during parameter burst");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_end == r_out_last))
        else $error("only a status result may close a transaction group");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_end) |-> (r_out_data[15:14] == STAT_OK))
        else $error("parameter result carries a status");

endmodule

@@ tb/tb_sync_framed_packet_receiver.sv @@
module tb_sync_framed_packet_receiver;
    import sfpr_pkg::*;

    typedef struct packed {
        logic       frame_end;
        logic [5:0] param_idx;
        logic [7:0] param_val;
        t_status    status;
        logic [7:0] device;
        logic [7:0] length;
        logic [7:0] unit;
        logic [7:0] method;
        logic       last;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // register shadows
    logic [7:0]  cfg_sync_first = 8'd85;
    logic [7:0]  cfg_sync_second = 8'd170;
    logic [15:0] cfg_timeout = 16'd1400;
    logic        cfg_cks_en = 1'b1;

    // deframer state
    int          frame_pos = 0;
    logic [7:0]  hdr_device = '0;
    logic [7:0]  hdr_length = '0;
    logic [7:0]  hdr_unit = '0;
    logic [7:0]  hdr_method = '0;
    logic [7:0]  byte_sum = '0;
    logic [15:0] idle_count = '0;
    logic [7:0]  param_mem [STORE_DEPTH];

    t_frame_result expected_frame_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int rx_hold_cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int param_results = 0;
    int status_count [4] = '{0, 0, 0, 0};

    sync_framed_packet_receiver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void push_result(logic end_flag, logic [5:0] idx, logic [7:0] val,
                                        t_status st, logic last_flag);
        t_frame_result r;
        r.frame_end = end_flag;
        r.param_idx = idx;
        r.param_val = val;
        r.status    = st;
        r.device    = hdr_device;
        r.length    = hdr_length;
        r.unit      = hdr_unit;
        r.method    = hdr_method;
        r.last      = last_flag;
        expected_frame_results.push_back(r);
        if (end_flag) begin
            status_count[st]++;
        end else begin
            param_results++;
        end
    endfunction

    function automatic void restart_hunt();
        frame_pos  = 0;
        idle_count = '0;
        byte_sum   = '0;
    endfunction

    task automatic deframe_transaction(logic req, logic [7:0] b);
        int          count;
        int          idx;
        int          i;
        logic [16:0] next_idle;
        if (req == REQ_TICK) begin
            if (frame_pos != 0) begin
                next_idle = idle_count + 17'd1;
                if (next_idle > {1'b0, cfg_timeout}) begin
                    push_result(1'b1, '0, '0, STAT_TIMEOUT, 1'b1);
                    restart_hunt();
                end else begin
                    idle_count = next_idle[15:0];
                end
            end
        end else begin
            idle_count = '0;
            count = frame_pos + 1;
            if (count == 1) begin
                if (b == cfg_sync_first) begin
                    hdr_device = '0;
                    hdr_length = '0;
                    hdr_unit   = '0;
                    hdr_method = '0;
                    byte_sum   = b;
                    frame_pos  = 1;
                end
            end else if (count == 2) begin
                if (b == cfg_sync_second) begin
                    byte_sum  = byte_sum + b;
                    frame_pos = 2;
                end else begin
                    restart_hunt();
                end
            end else if (count <= HDR_BYTES) begin
                case (count)
                    3: hdr_device = b;
                    4: hdr_length = b;
                    5: hdr_unit = b;
                    default: hdr_method = b;
                endcase
                byte_sum  = byte_sum + b;
                frame_pos = count;
            end else if (count < HDR_BYTES + 1 + int'(hdr_length)) begin
                idx = count - HDR_BYTES - 1;
                if (idx >= MAX_LEN || idx >= STORE_DEPTH) begin
                    push_result(1'b1, '0, '0, STAT_TOO_LONG, 1'b1);
                    restart_hunt();
                end else begin
                    param_mem[idx] = b;
                    byte_sum  = byte_sum + b;
                    frame_pos = count;
                end
            end else begin
                if (b == byte_sum || !cfg_cks_en) begin
                    for (i = 0; i < int'(hdr_length) && i < STORE_DEPTH; i++) begin
                        push_result(1'b0, 6'(i), param_mem[i], STAT_OK, 1'b0);
                    end
                    push_result(1'b1, '0, '0, STAT_OK, 1'b1);
                end else begin
                    push_result(1'b1, '0, '0, STAT_CHECKSUM, 1'b1);
                end
                restart_hunt();
            end
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_frame_results.size() == 0) begin
                $error("result with nothing pending: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = expected_frame_results.pop_front();
                check_field("is_frame_end", want.frame_end, m_axis_tuser);
                check_field("param_index", want.param_idx, m_axis_tdata[5:0]);
                check_field("param_byte", want.param_val, m_axis_tdata[13:6]);
                check_field("status", want.status, m_axis_tdata[15:14]);
                check_field("device_code", want.device, m_axis_tdata[23:16]);
                check_field("param_length", want.length, m_axis_tdata[31:24]);
                check_field("unit_code", want.unit, m_axis_tdata[39:32]);
                check_field("method_id", want.method, m_axis_tdata[47:40]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // hold off for rx_hold_cycles, then stall at random
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endfunction

    task automatic send_item(logic req, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        deframe_transaction(req, b);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  cfg_sync_first = value[7:0];
            CFG_SYNC_SECOND: cfg_sync_second = value[7:0];
            CFG_TIMEOUT:     cfg_timeout = value;
            default:         cfg_cks_en = value[0];
        endcase
        @(posedge i_clk);
    endtask

    // finish any open frame, hold input, drain every pending result
    task automatic settle();
        while (frame_pos != 0) begin
            send_item(REQ_BYTE, 8'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        while (expected_frame_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic frame_byte(logic [7:0] b, int tick_max);
        if (tick_max > 0 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(tick_max, 1)) send_item(REQ_TICK, 8'($urandom));
        end
        send_item(REQ_BYTE, b);
    endtask

    task automatic send_frame(logic [7:0] dev, logic [7:0] len, logic [7:0] unit,
                              logic [7:0] method, bit good_sum, int tick_max);
        logic [7:0] sum;
        logic [7:0] pb;
        int         n_params;
        n_params = (len > MAX_LEN) ? MAX_LEN + 1 : int'(len);
        sum = cfg_sync_first + cfg_sync_second + dev + len + unit + method;
        send_item(REQ_BYTE, cfg_sync_first);
        frame_byte(cfg_sync_second, tick_max);
        frame_byte(dev, tick_max);
        frame_byte(len, tick_max);
        frame_byte(unit, tick_max);
        frame_byte(method, tick_max);
        repeat (n_params) begin
            pb  = 8'($urandom);
            sum = sum + pb;
            frame_byte(pb, tick_max);
        end
        if (len <= MAX_LEN) begin
            frame_byte(good_sum ? sum : sum ^ 8'($urandom_range(255, 1)), tick_max);
        end
    endtask

    task automatic random_traffic(int n_items, int tick_max);
        int first;
        int pick;
        int len;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(3, 1)) send_item(1'($urandom_range(1)), 8'($urandom));
            end else if (pick < 14) begin
                send_item(REQ_BYTE, cfg_sync_first);
                send_item(REQ_BYTE, 8'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    len = $urandom_range(6);
                end else if (pick < 95) begin
                    len = $urandom_range(MAX_LEN, 7);
                end else begin
                    len = $urandom_range(255, MAX_LEN + 1);
                end
                send_frame(8'($urandom), 8'(len), 8'($urandom), 8'($urandom),
                           $urandom_range(7) != 0, tick_max);
            end
        end
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_item(REQ_TICK, 8'hA5);
        send_frame(8'h00, 8'd0, 8'h00, 8'h00, 1'b1, 0);
        send_frame(8'hFF, 8'd1, 8'hFF, 8'hFF, 1'b1, 0);
        // second sync byte equal to the first: drop it, then ignore the real second sync
        send_item(REQ_BYTE, cfg_sync_first);
        send_item(REQ_BYTE, cfg_sync_first);
        send_item(REQ_BYTE, cfg_sync_second);
        send_frame(8'h12, 8'd2, 8'h34, 8'h56, 1'b0, 0);
        send_frame(8'h9C, 8'd3, 8'h01, 8'h80, 1'b1, 2);
        settle();
    endtask

    task automatic test_timeout();
        set_idling(0, 0);
        write_reg(CFG_TIMEOUT, 16'd0);
        send_item(REQ_BYTE, cfg_sync_first);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_BYTE, cfg_sync_first);
        send_item(REQ_BYTE, cfg_sync_second);
        send_item(REQ_TICK, 8'hFF);
        settle();
        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(REQ_BYTE, cfg_sync_first);
        send_item(REQ_BYTE, cfg_sync_second);
        send_item(REQ_BYTE, 8'h07);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_BYTE, 8'h02);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_TICK, 8'h00);
        settle();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        send_frame(8'($urandom), 8'd3, 8'($urandom), 8'($urandom), 1'b1, 4);
        settle();
        write_reg(CFG_TIMEOUT, 16'd5);
        send_item(REQ_BYTE, cfg_sync_first);
        send_item(REQ_BYTE, cfg_sync_second);
        send_item(REQ_BYTE, 8'hC3);
        repeat (5) send_item(REQ_TICK, 8'($urandom));
        send_item(REQ_BYTE, 8'h01);
        repeat (6) send_item(REQ_TICK, 8'($urandom));
        settle();
        write_reg(CFG_TIMEOUT, 16'd6);
        set_idling(23, 23);
        random_traffic(10, 8);
        settle();
        write_reg(CFG_TIMEOUT, 16'd1400);
    endtask

    task automatic test_checksum_enable();
        set_idling(0, 0);
        write_reg(CFG_CKS_EN, 16'd0);
        send_frame(8'h21, 8'd2, 8'h43, 8'h65, 1'b0, 0);
        send_frame(8'hE0, 8'd0, 8'h0F, 8'hF0, 1'b1, 0);
        random_traffic(6, 2);
        settle();
        write_reg(CFG_CKS_EN, 16'd1);
        send_frame(8'h21, 8'd2, 8'h43, 8'h65, 1'b0, 0);
        settle();
    endtask

    task automatic test_sync_values();
        logic [15:0] firsts [3];
        logic [15:0] seconds [3];
        int k;
        firsts  = '{16'd0, 16'd255, 16'($urandom_range(255))};
        seconds = '{16'd255, 16'd0, 16'($urandom_range(255))};
        set_idling(23, 0);
        for (k = 0; k < 3; k++) begin
            write_reg(CFG_SYNC_FIRST, firsts[k]);
            write_reg(CFG_SYNC_SECOND, seconds[k]);
            random_traffic(5, 2);
            settle();
        end
        write_reg(CFG_SYNC_FIRST, 16'd85);
        write_reg(CFG_SYNC_SECOND, 16'd170);
    endtask

    task automatic test_length_overrun();
        set_idling(0, 0);
        send_frame(8'h11, 8'(MAX_LEN + 1), 8'h22, 8'h33, 1'b1, 0);
        send_frame(8'hFE, 8'd255, 8'h7F, 8'h01, 1'b1, 0);
        settle();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        rx_hold_cycles = 400;
        send_frame(8'h5A, 8'(MAX_LEN), 8'hA5, 8'h3C, 1'b1, 0);
        send_frame(8'($urandom), 8'd1, 8'($urandom), 8'($urandom), 1'b1, 0);
        while (rx_hold_cycles > 0) begin
            @(posedge i_clk);
        end
        settle();
    endtask

    task automatic test_random();
        set_idling(0, 0);
        random_traffic(8, 3);
        set_idling(65, 0);
        random_traffic(8, 3);
        set_idling(0, 65);
        random_traffic(8, 3);
        set_idling(23, 23);
        random_traffic(8, 3);
        settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_timeout();
        test_checksum_enable();
        test_sync_values();
        test_length_overrun();
        test_backpressure();
        test_random();
        settle();
        $display("Sent %0d byte/tick transactions, checked %0d results (%0d parameter bytes).",
                 items_sent, results_seen, param_results);
        $display("Frame status seen: %0d ok, %0d checksum, %0d timeout, %0d too long.",
                 status_count[STAT_OK], status_count[STAT_CHECKSUM],
                 status_count[STAT_TIMEOUT], status_count[STAT_TOO_LONG]);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
